### design/etm_pkg.sv
// Shared constants, register codes and control types of the embedding threshold matcher.
package etm_pkg;

	localparam int MAX_KNOWN  = 64;
	localparam int DIMS       = 128;
	localparam int VALUE_BITS = 16;

	localparam int OPCODE_W    = 1;
	localparam int ENTRY_IDX_W = 6;
	localparam int ELEM_IDX_W  = 7;
	localparam int ELEM_W      = 16;
	localparam int TOL_W       = 39;
	localparam int KCOUNT_W    = 7;
	localparam int ACC_W       = 40;
	localparam int CFG_IDX_W   = 1;

	localparam int ENT_W      = (MAX_KNOWN > 1) ? $clog2(MAX_KNOWN) : 1;
	localparam int CNT_W      = $clog2(MAX_KNOWN + 1);
	localparam int REF_DEPTH  = MAX_KNOWN * DIMS;
	localparam int REF_ADDR_W = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
	localparam int DIFF_W     = VALUE_BITS + 1;
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SUM_W      = ((SQ_W > ACC_W) ? SQ_W : ACC_W) + 1;

	localparam logic [TOL_W-1:0]    TOL_RESET    = TOL_W'(24159191);
	localparam logic [KCOUNT_W-1:0] KCOUNT_RESET = '0;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE_SQ = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_KNOWN_COUNT  = CFG_IDX_W'(1);

	localparam logic [OPCODE_W-1:0] OP_REF_WRITE = OPCODE_W'(0);
	localparam logic [OPCODE_W-1:0] OP_QUERY     = OPCODE_W'(1);

	typedef struct packed {
		logic                         en;
		logic [REF_ADDR_W-1:0]        addr;
		logic signed [VALUE_BITS-1:0] data;
	} ref_wr_t;

	typedef struct packed {
		logic                         issue;
		logic [ENT_W-1:0]             entry;
		logic [REF_ADDR_W-1:0]        ref_addr;
		logic signed [VALUE_BITS-1:0] value;
		logic                         elem_ok;
		logic                         start;
		logic                         clear;
	} pass_ctl_t;

	typedef struct packed {
		logic             busy;
		logic             matched;
		logic [ENT_W-1:0] best;
		logic [TOL_W-1:0] dist_sq;
	} pass_stat_t;

endpackage

### design/etm_item_if.sv
// Input item channel of the embedding threshold matcher.
interface etm_item_if;
	logic        valid;
	logic        ready;
	logic [0:0]  opcode;
	logic [5:0]  entry_index;
	logic [6:0]  element_index;
	logic signed [15:0] element_value;
	logic        last_element;
	logic        last_face;

	modport source(output valid, opcode, entry_index, element_index, element_value,
		last_element, last_face, input ready);
	modport sink(input valid, opcode, entry_index, element_index, element_value,
		last_element, last_face, output ready);
endinterface

### design/etm_result_if.sv
// Result channel of the embedding threshold matcher.
interface etm_result_if;
	logic        valid;
	logic        ready;
	logic        face_matched;
	logic [5:0]  match_entry;
	logic [38:0] match_distance_sq;
	logic        all_matched;
	logic        image_done;

	modport source(output valid, face_matched, match_entry, match_distance_sq, all_matched,
		image_done, input ready);
	modport sink(input valid, face_matched, match_entry, match_distance_sq, all_matched,
		image_done, output ready);
endinterface

### design/etm_cfg_if.sv
// Configuration write channel of the embedding threshold matcher.
interface etm_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [38:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

### design/etm_dist_unit.sv
// Reference store, distance accumulators and the shared square-accumulate-compare pipeline.
module etm_dist_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  etm_pkg::ref_wr_t    ref_wr,
	input  etm_pkg::pass_ctl_t  ctl,
	input  logic [38:0]         tolerance_sq,
	output etm_pkg::pass_stat_t stat
);
	import etm_pkg::*;

	logic signed [VALUE_BITS-1:0] ref_mem [REF_DEPTH];
	logic [ACC_W-1:0]             acc_mem [MAX_KNOWN];
	logic [MAX_KNOWN-1:0]         acc_vld_q;

	logic signed [VALUE_BITS-1:0] ref_rd_s2;
	logic [ACC_W-1:0]             acc_rd_s2;
	logic                         acc_hit_s2;
	logic [ENT_W-1:0]             entry_s2;
	logic                         vld_s2;

	logic [SQ_W-1:0]              sq_s3;
	logic [ACC_W-1:0]             acc_s3;
	logic [ENT_W-1:0]             entry_s3;
	logic                         vld_s3;

	logic signed [DIFF_W-1:0]     diff;
	logic signed [SQ_W-1:0]       prod;
	logic [SUM_W-1:0]             sum;
	logic [ACC_W-1:0]             acc_new;
	logic                         in_tol;

	logic                         matched_q;
	logic [ENT_W-1:0]             best_q;
	logic [TOL_W-1:0]             dist_q;

	always_ff @(posedge clk) begin
		if (ref_wr.en) begin
			ref_mem[ref_wr.addr] <= ref_wr.data;
		end
		ref_rd_s2 <= ref_mem[ctl.ref_addr];
	end

	always_ff @(posedge clk) begin
		if (vld_s3) begin
			acc_mem[entry_s3] <= acc_new;
		end
		acc_rd_s2 <= acc_mem[ctl.entry];
	end

	always_comb begin
		diff = DIFF_W'(ref_rd_s2) - DIFF_W'($signed(ctl.value));
		prod = diff * diff;
	end

	always_ff @(posedge clk) begin
		acc_hit_s2 <= acc_vld_q[ctl.entry];
		entry_s2   <= ctl.entry;
		sq_s3      <= SQ_W'(prod);
		acc_s3     <= acc_hit_s2 ? acc_rd_s2 : '0;
		entry_s3   <= entry_s2;
	end

	always_comb begin
		sum     = SUM_W'(acc_s3) + (ctl.elem_ok ? SUM_W'(sq_s3) : '0);
		acc_new = (sum > SUM_W'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
		in_tol  = acc_new <= ACC_W'(tolerance_sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			acc_vld_q <= '0;
			matched_q <= 1'b0;
			best_q    <= '0;
			dist_q    <= '0;
		end else begin
			vld_s2 <= ctl.issue;
			vld_s3 <= vld_s2;
			if (ctl.clear) begin
				acc_vld_q <= '0;
			end else if (vld_s3) begin
				acc_vld_q[entry_s3] <= 1'b1;
			end
			if (ctl.start) begin
				matched_q <= 1'b0;
				best_q    <= '0;
				dist_q    <= '0;
			end else if (vld_s3 && in_tol) begin
				matched_q <= 1'b1;
				best_q    <= entry_s3;
				dist_q    <= acc_new[TOL_W-1:0];
			end
		end
	end

	assign stat.busy    = vld_s2 | vld_s3;
	assign stat.matched = matched_q;
	assign stat.best    = best_q;
	assign stat.dist_sq = dist_q;

	// Entries only advance during a pass, so a stage never sees the entry of the stage ahead.
	a_entry_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && vld_s3 |-> entry_s2 != entry_s3)
		else $error("two pipeline stages hold the same entry");

	a_no_clear_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !vld_s2 && !vld_s3 && !ctl.issue)
		else $error("accumulators cleared while a pass is in flight");

	a_best_within: assert property (@(posedge clk) disable iff (!arst_n)
		!matched_q |-> best_q == '0 && dist_q == '0)
		else $error("best entry recorded without a match");

endmodule

### design/embedding_threshold_matcher_core.sv
// Top level of the embedding threshold matcher: configuration, pass sequencer and result register.
//
// Channel   Role   Transfer carries
// item      sink   opcode, entry_index, element_index, element_value, last_element, last_face
// result    source face_matched, match_entry, match_distance_sq, all_matched, image_done
// cfg       sink   index, data (0 is tolerance_sq, 1 is known_count)
//
// A reference write is taken in the idle state and starts no pass. A query element runs one
// pass of the shared square-accumulate-compare unit over the enrolled entries (known_count,
// capped at 64), one per cycle, then drains; with no entry enrolled it goes straight to finish.
// Reset is asynchronous and clears all accumulators at once; the reference store is not cleared.
// While a pass runs, item.ready is low; the next item is taken while a result still waits.
// A query end whose result finds the result register full holds until it is taken.
module embedding_threshold_matcher_core (
	input logic     clk,
	input logic     arst_n,
	etm_item_if.sink     item,
	etm_result_if.source result,
	etm_cfg_if.sink      cfg
);
	import etm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]                   state_q;
	logic [TOL_W-1:0]             tol_q;
	logic [KCOUNT_W-1:0]          kcount_q;
	logic [CNT_W-1:0]             count_q;
	logic [ENT_W-1:0]             ent_q;
	logic [REF_ADDR_W-1:0]        raddr_q;
	logic signed [VALUE_BITS-1:0] value_q;
	logic                         elem_ok_q;
	logic                         last_q;
	logic                         face_q;
	logic                         img_ok_q;

	logic                         out_vld_q;
	logic                         face_matched_q;
	logic [5:0]                   match_entry_q;
	logic [TOL_W-1:0]             match_dist_q;
	logic                         all_matched_q;
	logic                         image_done_q;

	logic                         item_xfer;
	logic                         in_entry_ok;
	logic                         in_elem_ok;
	logic [CNT_W-1:0]             count_clamp;
	logic                         last_issue;
	logic                         out_free;
	logic                         publish;
	logic                         ok_new;

	ref_wr_t                      ref_wr;
	pass_ctl_t                    ctl;
	pass_stat_t                   stat;

	assign item.ready = state_q == ST_IDLE;
	assign cfg.ready  = 1'b1;
	assign item_xfer  = item.valid && item.ready;

	always_comb begin
		in_entry_ok = 32'(item.entry_index) < MAX_KNOWN;
		in_elem_ok  = 32'(item.element_index) < DIMS;
		count_clamp = (32'(kcount_q) > MAX_KNOWN) ? CNT_W'(MAX_KNOWN) : CNT_W'(kcount_q);
		last_issue  = (CNT_W'(ent_q) + CNT_W'(1)) == count_q;
		out_free    = !out_vld_q || result.ready;
		publish     = (state_q == ST_FIN) && last_q && out_free;
		ok_new      = img_ok_q && stat.matched;
	end

	always_comb begin
		ref_wr.en   = item_xfer && (item.opcode == OP_REF_WRITE) && in_entry_ok && in_elem_ok;
		ref_wr.addr = REF_ADDR_W'(item.entry_index) * REF_ADDR_W'(DIMS)
			+ REF_ADDR_W'(item.element_index);
		ref_wr.data = VALUE_BITS'(item.element_value);
	end

	always_comb begin
		ctl.issue    = state_q == ST_RUN;
		ctl.entry    = ent_q;
		ctl.ref_addr = raddr_q;
		ctl.value    = value_q;
		ctl.elem_ok  = elem_ok_q;
		ctl.start    = item_xfer && (item.opcode == OP_QUERY);
		ctl.clear    = publish;
	end

	etm_dist_unit u_dist (
		.clk          (clk),
		.arst_n       (arst_n),
		.ref_wr       (ref_wr),
		.ctl          (ctl),
		.tolerance_sq (tol_q),
		.stat         (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_RESET;
			kcount_q <= KCOUNT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_TOLERANCE_SQ: tol_q    <= cfg.data;
				REG_KNOWN_COUNT:  kcount_q <= cfg.data[KCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item_xfer) begin
			value_q   <= VALUE_BITS'(item.element_value);
			elem_ok_q <= in_elem_ok;
			last_q    <= item.last_element;
			face_q    <= item.last_face;
			count_q   <= count_clamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ent_q   <= '0;
			raddr_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ent_q   <= '0;
					raddr_q <= REF_ADDR_W'(item.element_index);
					if (item_xfer && (item.opcode == OP_QUERY)
						&& (in_elem_ok || item.last_element)) begin
						state_q <= (count_clamp != '0) ? ST_RUN : ST_FIN;
					end
				end
				ST_RUN: begin
					ent_q   <= ent_q + ENT_W'(1);
					raddr_q <= raddr_q + REF_ADDR_W'(DIMS);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!stat.busy) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!last_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_ok_q  <= 1'b1;
			out_vld_q <= 1'b0;
		end else begin
			if (publish) begin
				img_ok_q  <= face_q ? 1'b1 : ok_new;
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (publish) begin
			face_matched_q <= stat.matched;
			match_entry_q  <= 6'(stat.best);
			match_dist_q   <= stat.dist_sq;
			all_matched_q  <= face_q && ok_new;
			image_done_q   <= face_q;
		end
	end

	assign result.valid             = out_vld_q;
	assign result.face_matched      = face_matched_q;
	assign result.match_entry       = match_entry_q;
	assign result.match_distance_sq = match_dist_q;
	assign result.all_matched       = all_matched_q;
	assign result.image_done        = image_done_q;

	a_idle_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		item_xfer |-> !stat.busy)
		else $error("item taken while the distance pipeline is busy");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q) == ST_FIN && $past(last_q))
		else $error("result raised outside the end of a query");

	a_no_match_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !face_matched_q |-> match_entry_q == '0 && match_dist_q == '0)
		else $error("unmatched result carries an entry or distance");

	a_all_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && all_matched_q |-> image_done_q && face_matched_q)
		else $error("all_matched set on a result that is not a matched last face");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the embedding threshold matcher core, predicting every result transfer.
module tb;
	import etm_pkg::*;

	localparam int CLK_HALF      = 4;
	localparam int SETTLE_CYCLES = 100;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RANDOM_ITEMS  = 500;
	localparam int HOLD_CYCLES   = 400;

	localparam logic [63:0]      ACC_MAX  = (64'd1 << ACC_W) - 64'd1;
	localparam logic [TOL_W-1:0] TOL_HIGH = TOL_W'(64'd549739036800);
	localparam logic [TOL_W-1:0] TOL_FULL = '1;

	typedef struct packed {
		logic [OPCODE_W-1:0]         opcode;
		logic [ENTRY_IDX_W-1:0]      entry;
		logic [ELEM_IDX_W-1:0]       elem;
		logic signed [ELEM_W-1:0]    value;
		logic                        last_el;
		logic                        last_face;
	} etm_item_t;

	typedef struct packed {
		logic                   face_matched;
		logic [ENTRY_IDX_W-1:0] match_entry;
		logic [TOL_W-1:0]       match_distance_sq;
		logic                   all_matched;
		logic                   image_done;
	} match_report_t;

	logic clk;
	logic arst_n;

	etm_item_if   item_ch();
	etm_result_if result_ch();
	etm_cfg_if    cfg_ch();

	embedding_threshold_matcher_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	logic signed [ELEM_W-1:0] gallery [MAX_KNOWN][DIMS];
	bit                       gallery_set [MAX_KNOWN][DIMS];
	logic [ACC_W-1:0]         dist_acc [MAX_KNOWN];
	bit                       image_clean;
	logic [TOL_W-1:0]         tol_limit;
	logic [KCOUNT_W-1:0]      enrolled;

	match_report_t awaited_reports[$];

	int  items_sent;
	int  random_items;
	int  reg_writes;
	int  results_seen;
	int  mismatches;
	int  hold_orders;
	int  cycles;
	bit  calm;

	always begin
		clk = 1'b0;
		#CLK_HALF;
		clk = 1'b1;
		#CLK_HALF;
	end

	function automatic int active_entries();
		return (enrolled > MAX_KNOWN) ? MAX_KNOWN : int'(enrolled);
	endfunction

	function automatic logic [ACC_W-1:0] entry_distance(int e, int col,
		logic signed [ELEM_W-1:0] val);
		longint      diff;
		logic [63:0] total;
		diff = longint'(gallery[e][col]) - longint'(val);
		total = {24'd0, dist_acc[e]} + 64'(diff * diff);
		return (total > ACC_MAX) ? ACC_MAX[ACC_W-1:0] : total[ACC_W-1:0];
	endfunction

	function automatic void step_matcher(etm_item_t it);
		int                     n;
		bit                     hit;
		logic [ENTRY_IDX_W-1:0] best;
		logic [TOL_W-1:0]       best_d;
		match_report_t          r;
		n = active_entries();
		if (it.opcode == OP_REF_WRITE) begin
			gallery[it.entry][it.elem] = it.value;
			gallery_set[it.entry][it.elem] = 1'b1;
			return;
		end
		for (int e = 0; e < n; e++)
			dist_acc[e] = entry_distance(e, it.elem, it.value);
		if (!it.last_el)
			return;
		hit = 1'b0;
		best = '0;
		best_d = '0;
		for (int e = 0; e < n; e++) begin
			if (dist_acc[e] <= {1'b0, tol_limit}) begin
				hit = 1'b1;
				best = ENTRY_IDX_W'(e);
				best_d = dist_acc[e][TOL_W-1:0];
			end
		end
		for (int e = 0; e < MAX_KNOWN; e++)
			dist_acc[e] = '0;
		if (!hit)
			image_clean = 1'b0;
		r.face_matched = hit;
		r.match_entry = best;
		r.match_distance_sq = best_d;
		r.all_matched = it.last_face && image_clean;
		r.image_done = it.last_face;
		if (it.last_face)
			image_clean = 1'b1;
		awaited_reports.insert(awaited_reports.size(), r);
	endfunction

	function automatic etm_item_t make_item(logic [OPCODE_W-1:0] op,
		logic [ENTRY_IDX_W-1:0] entry, logic [ELEM_IDX_W-1:0] elem,
		logic signed [ELEM_W-1:0] value, logic last_el, logic last_face);
		etm_item_t it;
		it.opcode = op;
		it.entry = entry;
		it.elem = elem;
		it.value = value;
		it.last_el = last_el;
		it.last_face = last_face;
		return it;
	endfunction

	function automatic etm_item_t random_ref_write();
		etm_item_t it;
		it.opcode = OP_REF_WRITE;
		it.entry = ENTRY_IDX_W'($urandom);
		it.elem = ELEM_IDX_W'($urandom);
		case ($urandom_range(0, 9))
		0: it.value = 16'sh8000;
		1: it.value = 16'sh7fff;
		default: it.value = ELEM_W'($urandom);
		endcase
		it.last_el = 1'($urandom);
		it.last_face = 1'($urandom);
		return it;
	endfunction

	task automatic send_item(input etm_item_t it);
		if (!calm && $urandom_range(0, 99) < 10) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 2 * active_entries() + 12)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.opcode <= it.opcode;
		item_ch.entry_index <= it.entry;
		item_ch.element_index <= it.elem;
		item_ch.element_value <= it.value;
		item_ch.last_element <= it.last_el;
		item_ch.last_face <= it.last_face;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		step_matcher(it);
		items_sent++;
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (awaited_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] data);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_TOLERANCE_SQ)
			tol_limit = data;
		else
			enrolled = data[KCOUNT_W-1:0];
		reg_writes++;
	endtask

	task automatic enroll_column(input int col, input bit use_fixed,
		input logic signed [ELEM_W-1:0] fixed_value);
		etm_item_t it;
		for (int e = 0; e < MAX_KNOWN; e++) begin
			it = random_ref_write();
			it.entry = ENTRY_IDX_W'(e);
			it.elem = ELEM_IDX_W'(col);
			if (use_fixed)
				it.value = fixed_value;
			send_item(it);
		end
	endtask

	task automatic run_query(input int len);
		int        cols[$];
		int        n;
		int        target;
		int        col;
		int        span;
		int        v;
		bit        ok;
		etm_item_t it;
		n = active_entries();
		for (int c = 0; c < DIMS; c++) begin
			ok = 1'b1;
			for (int e = 0; e < n; e++)
				if (!gallery_set[e][c])
					ok = 1'b0;
			if (ok)
				cols.insert(cols.size(), c);
		end
		target = (n > 0) ? $urandom_range(0, n - 1) : 0;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(0, 99) < 5)
				send_item(random_ref_write());
			col = cols[$urandom_range(0, cols.size() - 1)];
			it.opcode = OP_QUERY;
			it.entry = ENTRY_IDX_W'($urandom);
			it.elem = ELEM_IDX_W'(col);
			if (n == 0 || $urandom_range(0, 99) < 20) begin
				it.value = ELEM_W'($urandom);
			end else begin
				span = 1 << $urandom_range(0, 12);
				v = int'(gallery[target][col]) + int'($urandom_range(0, 2 * span)) - span;
				if (v > 32767)
					v = 32767;
				if (v < -32768)
					v = -32768;
				it.value = ELEM_W'(v);
			end
			it.last_el = (k == len - 1);
			it.last_face = (k == len - 1) ? ($urandom_range(0, 99) < 30)
				: ($urandom_range(0, 99) < 15);
			send_item(it);
		end
	endtask

	task automatic test_idle_defaults();
		send_item(make_item(OP_QUERY, 6'd0, 7'd0, 16'sd0, 1'b0, 1'b1));
		send_item(make_item(OP_QUERY, 6'd63, 7'd127, 16'sh8000, 1'b1, 1'b0));
		send_item(make_item(OP_QUERY, 6'd21, 7'd85, 16'sh7fff, 1'b1, 1'b1));
	endtask

	task automatic test_enrollment();
		enroll_column(0, 1'b0, '0);
		enroll_column(1, 1'b0, '0);
		enroll_column(DIMS - 1, 1'b1, 16'sd4096);
		send_item(make_item(OP_REF_WRITE, 6'd0, 7'd0, 16'sh7fff, 1'b1, 1'b1));
		send_item(make_item(OP_REF_WRITE, 6'd63, 7'd0, 16'sh8000, 1'b0, 1'b1));
	endtask

	task automatic test_directed_queries();
		logic signed [ELEM_W-1:0] v;
		logic [ACC_W-1:0]         d;
		write_reg(REG_KNOWN_COUNT, TOL_W'(MAX_KNOWN));
		send_item(make_item(OP_QUERY, 6'd0, 7'd127, 16'sd4096, 1'b1, 1'b1));
		write_reg(REG_KNOWN_COUNT, TOL_W'(127));
		send_item(make_item(OP_QUERY, 6'd5, 7'd127, 16'sd4196, 1'b1, 1'b0));
		write_reg(REG_TOLERANCE_SQ, '0);
		send_item(make_item(OP_QUERY, 6'd0, 7'd127, 16'sd4096, 1'b1, 1'b1));
		write_reg(REG_KNOWN_COUNT, TOL_W'(1));
		write_reg(REG_TOLERANCE_SQ, TOL_RESET);
		send_item(make_item(OP_QUERY, 6'd0, 7'd0, 16'sh8000, 1'b1, 1'b1));

		// The tolerance is set to one entry's exact distance, then just below it.
		write_reg(REG_KNOWN_COUNT, TOL_W'(MAX_KNOWN));
		v = ELEM_W'($urandom);
		d = entry_distance(40, 0, v);
		write_reg(REG_TOLERANCE_SQ, d[TOL_W-1:0]);
		send_item(make_item(OP_QUERY, 6'd0, 7'd0, v, 1'b1, 1'b0));
		if (d != 0)
			write_reg(REG_TOLERANCE_SQ, d[TOL_W-1:0] - 1'b1);
		send_item(make_item(OP_QUERY, 6'd0, 7'd0, v, 1'b1, 1'b1));

		write_reg(REG_TOLERANCE_SQ, TOL_FULL);
		write_reg(REG_KNOWN_COUNT, TOL_W'(2));
		send_item(make_item(OP_QUERY, 6'd9, 7'd1, 16'sd100, 1'b0, 1'b1));
		write_reg(REG_KNOWN_COUNT, TOL_W'(3));
		send_item(make_item(OP_QUERY, 6'd0, 7'd0, 16'sd0, 1'b0, 1'b0));
		send_item(make_item(OP_REF_WRITE, 6'd2, 7'd0, 16'sh7fff, 1'b1, 1'b1));
		send_item(make_item(OP_QUERY, 6'd0, 7'd127, -16'sd1, 1'b1, 1'b1));
	endtask

	task automatic test_result_backpressure();
		write_reg(REG_KNOWN_COUNT, TOL_W'(4));
		calm = 1'b1;
		hold_orders++;
		repeat (12)
			send_item(make_item(OP_QUERY, ENTRY_IDX_W'($urandom), 7'd0, ELEM_W'($urandom),
				1'b1, 1'($urandom)));
		calm = 1'b0;
	endtask

	task automatic test_accumulator_extremes();
		write_reg(REG_KNOWN_COUNT, TOL_W'(1));
		write_reg(REG_TOLERANCE_SQ, TOL_HIGH);
		send_item(make_item(OP_REF_WRITE, 6'd0, 7'd0, 16'sh7fff, 1'b0, 1'b0));
		for (int k = 0; k < DIMS; k++)
			send_item(make_item(OP_QUERY, 6'd0, 7'd0, 16'sh8000, k == DIMS - 1, 1'b0));
		write_reg(REG_TOLERANCE_SQ, TOL_FULL);
		for (int k = 0; k < 2 * DIMS + 3; k++)
			send_item(make_item(OP_QUERY, 6'd0, 7'd0, 16'sh8000, k == 2 * DIMS + 2, 1'b1));
	endtask

	task automatic test_random_traffic();
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			calm = (items_sent - start >= 150) && (items_sent - start < 310);
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				case ($urandom_range(0, 5))
				0: write_reg(REG_KNOWN_COUNT, '0);
				1: write_reg(REG_KNOWN_COUNT, TOL_W'(MAX_KNOWN));
				2: write_reg(REG_KNOWN_COUNT, TOL_W'($urandom_range(MAX_KNOWN + 1, 127)));
				default: write_reg(REG_KNOWN_COUNT, TOL_W'($urandom_range(1, MAX_KNOWN)));
				endcase
				case ($urandom_range(0, 5))
				0: write_reg(REG_TOLERANCE_SQ, TOL_RESET);
				1: write_reg(REG_TOLERANCE_SQ, '0);
				2: write_reg(REG_TOLERANCE_SQ, TOL_HIGH);
				3: write_reg(REG_TOLERANCE_SQ, TOL_W'($urandom_range(0, 32'h0400_0000)));
				default: write_reg(REG_TOLERANCE_SQ,
					TOL_W'({$urandom, $urandom} % (64'(TOL_HIGH) + 64'd1)));
				endcase
			end else if (pick < 8) begin
				enroll_column($urandom_range(0, DIMS - 1), 1'b0, '0);
			end else if (pick < 16) begin
				repeat ($urandom_range(1, 4)) send_item(random_ref_write());
			end else begin
				run_query(($urandom_range(0, 19) == 0) ? $urandom_range(8, 24)
					: $urandom_range(1, 5));
			end
		end
		random_items = items_sent - start;
		calm = 1'b0;
	endtask

	initial begin : receiver
		match_report_t got;
		match_report_t want;
		int            hold_taken;
		int            hold_left;
		hold_taken = 0;
		hold_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				got = {result_ch.face_matched, result_ch.match_entry,
					result_ch.match_distance_sq, result_ch.all_matched, result_ch.image_done};
				if (awaited_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result transfer: matched=%0d entry=%0d dist=%0d all=%0d done=%0d",
							got.face_matched, got.match_entry, got.match_distance_sq,
							got.all_matched, got.image_done);
				end else begin
					want = awaited_reports.pop_front();
					if (got.face_matched !== want.face_matched
						|| got.match_entry !== want.match_entry
						|| got.match_distance_sq !== want.match_distance_sq
						|| got.all_matched !== want.all_matched
						|| got.image_done !== want.image_done) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: expected matched=%0d entry=%0d dist=%0d all=%0d done=%0d, got matched=%0d entry=%0d dist=%0d all=%0d done=%0d",
								results_seen, want.face_matched, want.match_entry,
								want.match_distance_sq, want.all_matched, want.image_done,
								got.face_matched, got.match_entry, got.match_distance_sq,
								got.all_matched, got.image_done);
					end
				end
				results_seen++;
			end
			if (hold_orders != hold_taken) begin
				hold_taken = hold_orders;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
			end
		end
	end

	initial begin : watchdog
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("embedding_threshold_matcher_core: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.opcode = '0;
		item_ch.entry_index = '0;
		item_ch.element_index = '0;
		item_ch.element_value = '0;
		item_ch.last_element = 1'b0;
		item_ch.last_face = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		for (int e = 0; e < MAX_KNOWN; e++) begin
			dist_acc[e] = '0;
			for (int c = 0; c < DIMS; c++)
				gallery_set[e][c] = 1'b0;
		end
		image_clean = 1'b1;
		tol_limit = TOL_RESET;
		enrolled = KCOUNT_RESET;
		items_sent = 0;
		random_items = 0;
		reg_writes = 0;
		results_seen = 0;
		mismatches = 0;
		hold_orders = 0;
		calm = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_defaults();
		test_enrollment();
		test_directed_queries();
		test_result_backpressure();
		test_accumulator_extremes();
		test_random_traffic();

		wait_idle();
		$display("covered %0d items (%0d random), %0d checked results, %0d register writes",
			items_sent, random_items, results_seen, reg_writes);
		$display("including empty gallery, ties, exact tolerance, saturation and a %0d-cycle hold-off",
			HOLD_CYCLES);
		if (mismatches == 0 && awaited_reports.size() == 0) begin
			$display("embedding_threshold_matcher_core: match");
		end else begin
			$display("embedding_threshold_matcher_core: mismatch");
		end
		$finish;
	end

endmodule
